[design/rpcr_pkg.sv]
`default_nettype none

package rpcr_pkg;

  // Disk lanes are set by the 8-bit column masks and the 3-bit disk index.
  localparam int MAX_DISKS  = 8;
  localparam int DISK_IDX_W = 3;
  localparam int DCNT_W     = 4;
  localparam int BPB_W      = 7;
  localparam int DATA_W     = 64;
  localparam int COL_W      = 8;

  localparam int DEF_BLOCK_BITS  = 64;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_DISK_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_BLOCK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ODD     = 2'd2;

  localparam logic [DCNT_W-1:0] RST_DISK_COUNT     = 4'd3;
  localparam logic [BPB_W-1:0]  RST_BITS_PER_BLOCK = 7'd8;

  localparam logic RES_DATA    = 1'b0;
  localparam logic RES_VERDICT = 1'b1;

  typedef struct packed {
    logic [DCNT_W-1:0] disk_count;
    logic [BPB_W-1:0]  bits_per_block;
    logic              parity_odd;
  } rpcr_cfg_t;

  // Per-row bookkeeping stored next to the block words in the queue.
  typedef struct packed {
    logic                  verdict_valid;
    logic                  has_verdict;
    logic                  emit_data;
    logic [DISK_IDX_W-1:0] parity_disk;
    logic [DCNT_W-1:0]     disk_count;
  } rpcr_meta_t;

  typedef struct packed {
    logic                  kind;
    logic [DATA_W-1:0]     data_word;
    logic [DISK_IDX_W-1:0] disk_index;
    logic                  set_valid;
    logic                  last;
  } rpcr_result_t;

endpackage

`default_nettype wire

[design/rpcr_ram.sv]
`default_nettype none

module rpcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/rpcr_column.sv]
`default_nettype none

module rpcr_column #(
  parameter int MAX_BLOCK_BITS = rpcr_pkg::DEF_BLOCK_BITS
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire rpcr_pkg::rpcr_cfg_t                          cfg,
  input  wire logic                                         accept,
  input  wire logic [rpcr_pkg::COL_W-1:0]                   bit_values,
  input  wire logic [rpcr_pkg::COL_W-1:0]                   erased_mask,
  input  wire logic                                         last_in_set,
  output logic                                              push,
  output rpcr_pkg::rpcr_meta_t                              meta,
  output logic [rpcr_pkg::MAX_DISKS*MAX_BLOCK_BITS-1:0]     words
);

  import rpcr_pkg::*;

  localparam int PW = (MAX_BLOCK_BITS > 1) ? $clog2(MAX_BLOCK_BITS) : 1;

  logic [PW-1:0]             pos_r, pos_nxt;
  logic [DISK_IDX_W-1:0]     pdisk_r, pdisk_nxt;
  logic                      failed_r, failed_nxt;
  logic [MAX_BLOCK_BITS-1:0] lane_r [MAX_DISKS];
  logic [MAX_BLOCK_BITS-1:0] lane_nxt [MAX_DISKS];

  logic [DCNT_W-1:0]         d_eff;
  logic [BPB_W-1:0]          s_eff;
  logic [MAX_DISKS-1:0]      dmask, erased, vals, vals_fix;
  logic [MAX_BLOCK_BITS-1:0] word_mask;
  logic                      no_unknown, one_unknown, col_fail, failed_now, block_end;
  logic [DCNT_W-1:0]         pdisk_inc;

  // Clamp registers into their legal ranges.
  always_comb begin
    if (cfg.disk_count < DCNT_W'(2)) begin
      d_eff = DCNT_W'(2);
    end else if (cfg.disk_count > DCNT_W'(MAX_DISKS)) begin
      d_eff = DCNT_W'(MAX_DISKS);
    end else begin
      d_eff = cfg.disk_count;
    end
    if (cfg.bits_per_block == '0) begin
      s_eff = BPB_W'(1);
    end else if (cfg.bits_per_block > BPB_W'(MAX_BLOCK_BITS)) begin
      s_eff = BPB_W'(MAX_BLOCK_BITS);
    end else begin
      s_eff = cfg.bits_per_block;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DISKS; i++) begin
      dmask[i] = DCNT_W'(i) < d_eff;
    end
    for (int k = 0; k < MAX_BLOCK_BITS; k++) begin
      word_mask[k] = BPB_W'(k) < s_eff;
    end
  end

  // Parity check and single-erasure rebuild.
  always_comb begin
    erased      = erased_mask & dmask;
    vals        = bit_values & dmask & ~erased;
    no_unknown  = erased == '0;
    one_unknown = !no_unknown && ((erased & (erased - MAX_DISKS'(1))) == '0);
    vals_fix    = vals;
    col_fail    = 1'b0;
    if (one_unknown) begin
      if ((^vals) ^ cfg.parity_odd) begin
        vals_fix = vals | erased;
      end
    end else if (no_unknown) begin
      col_fail = (^vals) != cfg.parity_odd;
    end else begin
      col_fail = 1'b1;
    end
    failed_now = failed_r | col_fail;
    block_end  = (BPB_W'(pos_r) + BPB_W'(1)) >= s_eff;
    pdisk_inc  = DCNT_W'(pdisk_r) + DCNT_W'(1);
  end

  // Shift each present disk's bit into its lane; restart lanes at a block's
  // first column. Hold the lanes of disks beyond the current count.
  always_comb begin
    for (int i = 0; i < MAX_DISKS; i++) begin
      if (!dmask[i]) begin
        lane_nxt[i] = lane_r[i];
      end else if (pos_r == '0) begin
        lane_nxt[i] = MAX_BLOCK_BITS'(vals_fix[i]);
      end else begin
        lane_nxt[i] = MAX_BLOCK_BITS'({lane_r[i], vals_fix[i]});
      end
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    pdisk_nxt  = pdisk_r;
    failed_nxt = failed_r;
    if (accept) begin
      failed_nxt = failed_now;
      if (block_end) begin
        pos_nxt   = '0;
        pdisk_nxt = (pdisk_inc >= d_eff) ? '0 : DISK_IDX_W'(pdisk_inc);
      end else begin
        pos_nxt = pos_r + PW'(1);
      end
      if (last_in_set) begin
        pos_nxt    = '0;
        pdisk_nxt  = '0;
        failed_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    meta.verdict_valid = !failed_now;
    meta.has_verdict   = last_in_set;
    meta.emit_data     = block_end && !failed_now;
    meta.parity_disk   = pdisk_r;
    meta.disk_count    = d_eff;
    push               = accept && (meta.emit_data || last_in_set);
    for (int i = 0; i < MAX_DISKS; i++) begin
      words[i*MAX_BLOCK_BITS +: MAX_BLOCK_BITS] = lane_nxt[i] & word_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      pdisk_r  <= '0;
      failed_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      pdisk_r  <= pdisk_nxt;
      failed_r <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_DISKS; i++) begin
        lane_r[i] <= lane_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

[design/rpcr_drain.sv]
`default_nettype none

module rpcr_drain #(
  parameter int MAX_BLOCK_BITS = rpcr_pkg::DEF_BLOCK_BITS,
  parameter int QUEUE_DEPTH    = rpcr_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      push,
  input  wire rpcr_pkg::rpcr_meta_t                      push_meta,
  input  wire logic [rpcr_pkg::MAX_DISKS*MAX_BLOCK_BITS-1:0] push_words,
  output logic                                           full,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output rpcr_pkg::rpcr_result_t                         out_res
);

  import rpcr_pkg::*;

  localparam int WORDS_W = MAX_DISKS * MAX_BLOCK_BITS;
  localparam int ROW_W   = $bits(rpcr_meta_t) + WORDS_W;
  localparam int AW      = $clog2(QUEUE_DEPTH);
  localparam int CW      = AW + 1;

  logic [AW-1:0]      wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      rows_r, rows_nxt;
  logic               busy_r, busy_nxt, vphase_r, vphase_nxt;
  logic [DCNT_W-1:0]  cur_r, cur_nxt;
  logic               out_valid_r, out_valid_nxt;
  rpcr_result_t       res_r, res_nxt;

  logic [ROW_W-1:0]          rdata;
  rpcr_meta_t                rd_meta;
  logic [MAX_BLOCK_BITS-1:0] rd_word [MAX_DISKS];
  logic                      re, emit, vphase_eff, data_more, item_last;
  logic [DCNT_W-1:0]         eff_cur, next_cur;

  rpcr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_row_ram (
    .clk     (clk),
    .we      (push),
    .waddr   (wr_ptr_r),
    .wdata   ({push_meta, push_words}),
    .re      (re),
    .raddr   (rd_ptr_r),
    .rdata_r (rdata)
  );

  assign rd_meta = rdata[ROW_W-1 -: $bits(rpcr_meta_t)];

  for (genvar g = 0; g < MAX_DISKS; g++) begin : g_word
    assign rd_word[g] = rdata[g*MAX_BLOCK_BITS +: MAX_BLOCK_BITS];
  end

  // Walk the loaded row: data disks in ascending order, skip parity, then the verdict if the row has one.
  always_comb begin
    vphase_eff = vphase_r || !rd_meta.emit_data;
    eff_cur    = (cur_r == DCNT_W'(rd_meta.parity_disk)) ? cur_r + DCNT_W'(1) : cur_r;
    next_cur   = eff_cur + DCNT_W'(1);
    if (next_cur == DCNT_W'(rd_meta.parity_disk)) begin
      next_cur = next_cur + DCNT_W'(1);
    end
    data_more = next_cur < rd_meta.disk_count;
    item_last = vphase_eff || (!data_more && !rd_meta.has_verdict);
  end

  always_comb begin
    full = rows_r == CW'(QUEUE_DEPTH);
    emit = busy_r && (!out_valid_r || out_ready);
    re   = (rows_r != '0) && (!busy_r || (emit && item_last));
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = re ? rd_ptr_r + AW'(1) : rd_ptr_r;
    rows_nxt   = rows_r + CW'(push) - CW'(re);
    busy_nxt   = busy_r;
    cur_nxt    = cur_r;
    vphase_nxt = vphase_r;
    if (re) begin
      busy_nxt   = 1'b1;
      cur_nxt    = '0;
      vphase_nxt = 1'b0;
    end else if (emit) begin
      if (item_last) begin
        busy_nxt = 1'b0;
      end else if (!vphase_eff) begin
        if (data_more) begin
          cur_nxt = next_cur;
        end else begin
          vphase_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      res_nxt.last  = item_last;
      if (vphase_eff) begin
        res_nxt.kind       = RES_VERDICT;
        res_nxt.data_word  = '0;
        res_nxt.disk_index = '0;
        res_nxt.set_valid  = rd_meta.verdict_valid;
      end else begin
        res_nxt.kind       = RES_DATA;
        res_nxt.data_word  = DATA_W'(rd_word[eff_cur[DISK_IDX_W-1:0]]);
        res_nxt.disk_index = eff_cur[DISK_IDX_W-1:0];
        res_nxt.set_valid  = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      rows_r      <= '0;
      busy_r      <= 1'b0;
      cur_r       <= '0;
      vphase_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rows_r      <= rows_nxt;
      busy_r      <= busy_nxt;
      cur_r       <= cur_nxt;
      vphase_r    <= vphase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r <= CW'(QUEUE_DEPTH))
    else $error("row queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("row pushed into a full queue");

  a_row_done: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && item_last && rows_r == '0) |=> !busy_r)
    else $error("row still busy after its last word");

endmodule

`default_nettype wire

[design/raid_parity_check_rebuild.sv]
`default_nettype none

// Streaming parity check and single-erasure rebuild for a rotating-parity disk
// set. Each input word is one bit column (one bit per disk plus an erasure mask,
// tlast on the set's final column); one column is taken every cycle. A column
// with one erased bit gets it rebuilt, two or more erasures or a parity
// mismatch mark the set failed. At each block end of a still-good set, and at
// the set's final column, the block (one word per disk) is written as one row
// into a small row queue RAM, QUEUE_DEPTH rows deep; the output side reads a row
// and sends disk_count-1 data words, one per cycle while out_tready is high,
// skipping the parity disk (none for a failed set), then the verdict word when
// the set ends there. in_tready drops only while the row queue is full, so a
// sustained column rate of one per cycle holds as long as the consumer takes the
// words of each block before QUEUE_DEPTH further blocks complete. No clearing pass
// follows reset; configuration is taken at any time through cfg_valid/cfg_ready
// but should only change while the block is idle.
module raid_parity_check_rebuild #(
  parameter int MAX_BLOCK_BITS = rpcr_pkg::DEF_BLOCK_BITS,
  parameter int QUEUE_DEPTH    = rpcr_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // config write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rpcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rpcr_pkg::CFG_DATA_W-1:0]   cfg_data,
  // column input
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [15:0]                       in_tdata,  // [7:0] bit_values, [15:8] erased_mask
  input  wire logic                              in_tlast,  // last_in_set
  // result output
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [71:0]                            out_tdata, // [63:0] data_word, [66:64] disk_index,
                                                            // [67] set_valid, [71:68] zero
  output logic                                   out_tuser, // result_kind
  output logic                                   out_tlast  // last
);

  import rpcr_pkg::*;

  rpcr_cfg_t    cfg_r, cfg_nxt;
  logic         in_accept, push, full;
  rpcr_meta_t   push_meta;
  logic [MAX_DISKS*MAX_BLOCK_BITS-1:0] push_words;
  rpcr_result_t res;

  // Register writes are always accepted; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DISK_COUNT:     cfg_nxt.disk_count     = cfg_data[DCNT_W-1:0];
        CFG_BITS_PER_BLOCK: cfg_nxt.bits_per_block = cfg_data[BPB_W-1:0];
        CFG_PARITY_ODD:     cfg_nxt.parity_odd     = cfg_data[0];
        default:            cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.disk_count     <= RST_DISK_COUNT;
      cfg_r.bits_per_block <= RST_BITS_PER_BLOCK;
      cfg_r.parity_odd     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Hold columns only while the row queue has no room for a finished block.
  assign in_tready = !full;
  assign in_accept = in_tvalid && in_tready;

  rpcr_column #(
    .MAX_BLOCK_BITS (MAX_BLOCK_BITS)
  ) u_column (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (in_accept),
    .bit_values  (in_tdata[7:0]),
    .erased_mask (in_tdata[15:8]),
    .last_in_set (in_tlast),
    .push        (push),
    .meta        (push_meta),
    .words       (push_words)
  );

  rpcr_drain #(
    .MAX_BLOCK_BITS (MAX_BLOCK_BITS),
    .QUEUE_DEPTH    (QUEUE_DEPTH)
  ) u_drain (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_meta  (push_meta),
    .push_words (push_words),
    .full       (full),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {4'b0000, res.set_valid, res.disk_index, res.data_word};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

`default_nettype wire
